>>> sv/mkwd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-key window debouncer package
// Shared widths, reset values, register indexes and the per-key
// configuration bundle.
// ----------------------------------------------------------------------------
package mkwd_pkg;

    localparam int NUM_KEYS_DEF = 4;
    localparam int CNT_W        = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_DATA_W-1:0] WINDOW_RST = 8'd20;
    localparam logic [CFG_DATA_W-1:0] THRESH_RST = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] window;
        logic [CNT_W-1:0] thresh;
    } t_key_cfg;

endpackage
`default_nettype wire

>>> sv/mkwd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Debouncer tick channel
// Valid/ready channel carrying the edge mask and the raw key levels.
// ----------------------------------------------------------------------------
interface mkwd_in_if #(
    parameter int NUM_KEYS = mkwd_pkg::NUM_KEYS_DEF
);
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] edge_mask;
    logic [NUM_KEYS-1:0] key_levels;

    modport source (output valid, output edge_mask, output key_levels, input ready);
    modport sink   (input valid, input edge_mask, input key_levels, output ready);
endinterface
`default_nettype wire

>>> sv/mkwd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Debouncer result channel
// Valid/ready channel carrying the stable key states and the change mask.
// ----------------------------------------------------------------------------
interface mkwd_out_if #(
    parameter int NUM_KEYS = mkwd_pkg::NUM_KEYS_DEF
);
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] stable_keys;
    logic [NUM_KEYS-1:0] changed_keys;

    modport source (output valid, output stable_keys, output changed_keys, input ready);
    modport sink   (input valid, input stable_keys, input changed_keys, output ready);
endinterface
`default_nettype wire

>>> sv/mkwd_key.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Debouncer key cell
// Window timer and differing-sample counter of one key; flags a toggle
// of the stable state when the window closes with enough differing samples.
// ----------------------------------------------------------------------------
module mkwd_key (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  mkwd_pkg::t_key_cfg  i_cfg,
    input  wire                 i_edge,
    input  wire                 i_level,
    input  wire                 i_stable,
    output logic                o_toggle
);
    import mkwd_pkg::*;

    logic [CNT_W-1:0] r_timer, n_timer;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] w_timer_ld;
    logic [CNT_W-1:0] w_timer_dec;
    logic [CNT_W-1:0] w_count_inc;
    logic             w_active;
    logic             w_expire;

    always_comb begin
        // An edge restarts the window; the count carries on.
        w_timer_ld  = i_edge ? i_cfg.window : r_timer;
        w_active    = (w_timer_ld != '0);
        w_timer_dec = w_timer_ld - {{(CNT_W-1){1'b0}}, 1'b1};
        w_count_inc = ((i_level ^ i_stable) && (r_count != CNT_MAX))
                    ? r_count + {{(CNT_W-1){1'b0}}, 1'b1} : r_count;
        w_expire    = w_active && (w_timer_dec == '0);
        o_toggle    = w_expire && (w_count_inc > i_cfg.thresh);
        n_timer     = w_active ? w_timer_dec : '0;
        if (!w_active) begin
            n_count = r_count;
        end else if (w_expire) begin
            n_count = '0;
        end else begin
            n_count = w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_timer <= n_timer;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> sv/multi_key_window_debouncer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-key window debouncer
// Per-key window debouncing of raw key levels, one tick per word.
// ----------------------------------------------------------------------------
// Each input word is one tick and yields exactly one result word. A new word
// is taken every clock cycle while the output side keeps up; a word passes
// through an input register and then a result register, and its result can
// be taken once the output side is ready. All keys are updated in parallel
// in their own cells, and the result register lets the next tick be accepted
// while a result waits to be taken. Window length and threshold are written
// through the configuration port; the user must write them only while the
// block is idle, as the block itself does not enforce this.
module multi_key_window_debouncer #(
    parameter int NUM_KEYS = mkwd_pkg::NUM_KEYS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [mkwd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [mkwd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    mkwd_in_if.sink                              i_in,
    mkwd_out_if.source                           o_out
);
    import mkwd_pkg::*;

    t_key_cfg            r_cfg;
    logic                r_in_valid;
    logic [NUM_KEYS-1:0] r_edges;
    logic [NUM_KEYS-1:0] r_levels;
    logic [NUM_KEYS-1:0] r_stable;
    logic                r_out_valid;
    logic [NUM_KEYS-1:0] r_out_stable;
    logic [NUM_KEYS-1:0] r_out_changed;
    logic [NUM_KEYS-1:0] w_toggle;
    logic [NUM_KEYS-1:0] n_stable;
    logic                w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window <= WINDOW_RST;
            r_cfg.thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_TICKS:     r_cfg.window <= i_cfg_data;
                REG_ACCEPT_THRESHOLD: r_cfg.thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The held word moves on when the result register is empty or drained.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_edges  <= i_in.edge_mask;
            r_levels <= i_in.key_levels;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        mkwd_key u_key (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (w_advance),
            .i_cfg    (r_cfg),
            .i_edge   (r_edges[k]),
            .i_level  (r_levels[k]),
            .i_stable (r_stable[k]),
            .o_toggle (w_toggle[k])
        );
    end

    assign n_stable = r_stable ^ w_toggle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_stable    <= n_stable;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_stable  <= n_stable;
            r_out_changed <= w_toggle;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.stable_keys  = r_out_stable;
    assign o_out.changed_keys = r_out_changed;

endmodule
`default_nettype wire

>>> sv/mkwd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Debouncer port checker
// Watches the ports of the debouncer and checks result consistency,
// reset behaviour and flow control.
// ----------------------------------------------------------------------------
module mkwd_checker #(
    parameter int NUM_KEYS = mkwd_pkg::NUM_KEYS_DEF
) (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [NUM_KEYS-1:0] i_out_stable,
    input wire [NUM_KEYS-1:0] i_out_changed
);
    logic [NUM_KEYS-1:0] r_last_stable;
    logic                w_out_take;

    assign w_out_take = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stable <= '0;
        end else if (w_out_take) begin
            r_last_stable <= i_out_stable;
        end
    end

    // Each result differs from the previous one exactly in the changed keys.
    a_stable_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_stable == (r_last_stable ^ i_out_changed)))
        else $error("stable keys do not follow the change mask");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_stable) && $stable(i_out_changed)))
        else $error("stalled result word changed");

endmodule

bind multi_key_window_debouncer mkwd_checker #(
    .NUM_KEYS (NUM_KEYS)
) u_mkwd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_stable  (o_out.stable_keys),
    .i_out_changed (o_out.changed_keys)
);
`default_nettype wire

>>> dv/multi_key_window_debouncer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-key window debouncer regression
// Drives tick words through the block and checks every result word against
// a cycle-free model of the per-key window timers, the differ counters and
// the debounced states. A short scripted part comes first, then bouncing-key
// traffic under several window and threshold settings and handshake loads.
// ----------------------------------------------------------------------------
module multi_key_window_debouncer_test;
    import mkwd_pkg::*;

    localparam int NUM_KEYS   = NUM_KEYS_DEF;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [NUM_KEYS-1:0] stable_keys;
        logic [NUM_KEYS-1:0] changed_keys;
    } t_key_report;

    typedef enum logic [0:0] {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [NUM_KEYS-1:0]      edges;
        logic [NUM_KEYS-1:0]      levels;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        logic                     pinned;
        t_key_report              want;
    } t_script_row;

    // Scripted opening: reset state, shortest window, zero window, a restart
    // while the window runs, and a threshold that can never be exceeded.
    localparam t_script_row SCRIPT [21] = '{
        '{ROW_TICK, 4'h0, 4'h0, REG_WINDOW_TICKS,     8'd0,   1'b1, '{4'h0, 4'h0}},
        '{ROW_CFG,  4'h0, 4'h0, REG_WINDOW_TICKS,     8'd1,   1'b0, '{4'h0, 4'h0}},
        '{ROW_CFG,  4'h0, 4'h0, REG_ACCEPT_THRESHOLD, 8'd0,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'hF, 4'hF, REG_WINDOW_TICKS,     8'd0,   1'b1, '{4'hF, 4'hF}},
        '{ROW_TICK, 4'hF, 4'h0, REG_WINDOW_TICKS,     8'd0,   1'b1, '{4'h0, 4'hF}},
        '{ROW_TICK, 4'h0, 4'hF, REG_WINDOW_TICKS,     8'd0,   1'b1, '{4'h0, 4'h0}},
        '{ROW_CFG,  4'h0, 4'h0, REG_WINDOW_TICKS,     8'd0,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'hF, 4'hF, REG_WINDOW_TICKS,     8'd0,   1'b1, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'hA, 4'h5, REG_WINDOW_TICKS,     8'd0,   1'b1, '{4'h0, 4'h0}},
        '{ROW_CFG,  4'h0, 4'h0, REG_WINDOW_TICKS,     8'd3,   1'b0, '{4'h0, 4'h0}},
        '{ROW_CFG,  4'h0, 4'h0, REG_ACCEPT_THRESHOLD, 8'd1,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'h1, 4'h1, REG_WINDOW_TICKS,     8'd0,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'h0, 4'h1, REG_WINDOW_TICKS,     8'd0,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'h1, 4'h0, REG_WINDOW_TICKS,     8'd0,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'h0, 4'h0, REG_WINDOW_TICKS,     8'd0,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'h0, 4'h0, REG_WINDOW_TICKS,     8'd0,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'h6, 4'h6, REG_WINDOW_TICKS,     8'd0,   1'b0, '{4'h0, 4'h0}},
        '{ROW_CFG,  4'h0, 4'h0, REG_ACCEPT_THRESHOLD, 8'd255, 1'b0, '{4'h0, 4'h0}},
        '{ROW_CFG,  4'h0, 4'h0, REG_WINDOW_TICKS,     8'd2,   1'b0, '{4'h0, 4'h0}},
        '{ROW_TICK, 4'hF, 4'hE, REG_WINDOW_TICKS,     8'd0,   1'b1, '{4'h1, 4'h0}},
        '{ROW_TICK, 4'h0, 4'hE, REG_WINDOW_TICKS,     8'd0,   1'b1, '{4'h1, 4'h0}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mkwd_in_if  #(.NUM_KEYS(NUM_KEYS)) tick_ch ();
    mkwd_out_if #(.NUM_KEYS(NUM_KEYS)) report_ch ();

    multi_key_window_debouncer #(.NUM_KEYS(NUM_KEYS)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_ch),
        .o_out      (report_ch)
    );

    // Model state and its copy of the registers.
    logic [CNT_W-1:0]      window_len;
    logic [CNT_W-1:0]      accept_thr;
    logic [CNT_W-1:0]      key_timer [NUM_KEYS];
    logic [CNT_W-1:0]      miss_count [NUM_KEYS];
    logic [NUM_KEYS-1:0]   debounced;

    t_key_report           reports_due [$];
    logic                  tick_pinned;
    t_key_report           tick_pinned_rpt;

    // Bouncing-key stimulus state.
    logic [NUM_KEYS-1:0]   raw_level;
    logic [NUM_KEYS-1:0]   settle_level;
    int                    bounce_left [NUM_KEYS];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int stall_cycles;
    int fails;
    int ticks_taken;
    int words_checked;
    int toggles_seen;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic debounce_tick(input logic [NUM_KEYS-1:0] edges,
                                 input logic [NUM_KEYS-1:0] levels,
                                 output t_key_report rpt);
        logic [NUM_KEYS-1:0] toggled;
        int k;
        toggled = '0;
        for (k = 0; k < NUM_KEYS; k++) begin
            if (edges[k]) begin
                key_timer[k] = window_len;
            end
            if (key_timer[k] != 0) begin
                key_timer[k] = key_timer[k] - 1'b1;
                if (levels[k] != debounced[k] && miss_count[k] != CNT_MAX) begin
                    miss_count[k] = miss_count[k] + 1'b1;
                end
                if (key_timer[k] == 0) begin
                    if (miss_count[k] > accept_thr) begin
                        toggled[k] = 1'b1;
                    end
                    miss_count[k] = '0;
                end
            end
        end
        debounced = debounced ^ toggled;
        rpt.stable_keys  = debounced;
        rpt.changed_keys = toggled;
    endtask

    always @(posedge i_clk) begin : check_words
        t_key_report predicted;
        t_key_report want;
        if (i_rst_n) begin
            if (tick_ch.valid && tick_ch.ready) begin
                debounce_tick(tick_ch.edge_mask, tick_ch.key_levels, predicted);
                reports_due.push_back(tick_pinned ? tick_pinned_rpt : predicted);
                ticks_taken++;
            end
            if (report_ch.valid && report_ch.ready) begin
                if (reports_due.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    fails++;
                end else begin
                    want = reports_due.pop_front();
                    if (report_ch.stable_keys !== want.stable_keys) begin
                        $error("stable_keys: expected %h, got %h",
                               want.stable_keys, report_ch.stable_keys);
                        fails++;
                    end
                    if (report_ch.changed_keys !== want.changed_keys) begin
                        $error("changed_keys: expected %h, got %h",
                               want.changed_keys, report_ch.changed_keys);
                        fails++;
                    end
                    words_checked++;
                    toggles_seen += $countones(report_ch.changed_keys);
                end
            end
        end
        if ((tick_ch.valid && tick_ch.ready) || (report_ch.valid && report_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("multi_key_window_debouncer regression: fail");
        $finish;
    end

    // Result side: random back-pressure, or a long hold-off when requested.
    initial begin
        report_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                report_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_tick(input logic [NUM_KEYS-1:0] edges,
                             input logic [NUM_KEYS-1:0] levels,
                             input logic pinned, input t_key_report want);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.edge_mask  <= edges;
        tick_ch.key_levels <= levels;
        tick_pinned        <= pinned;
        tick_pinned_rpt    <= want;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
    endtask

    // Registers only change with no word in flight and every window closed,
    // so a per-key copy of the settings taken at window start cannot matter.
    // The closing ticks repeat the debounced levels, so they add no
    // differing samples of their own.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int longest;
        int k;
        drain();
        longest = 0;
        for (k = 0; k < NUM_KEYS; k++) begin
            if (int'(key_timer[k]) > longest) longest = int'(key_timer[k]);
        end
        repeat (longest) send_tick('0, debounced, 1'b0, '0);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_WINDOW_TICKS:     window_len = val;
            REG_ACCEPT_THRESHOLD: accept_thr = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Keys change level now and then, bounce for a few ticks and settle.
    // Edges follow real level changes, with a few spurious ones; one word in
    // ten is pure noise.
    task automatic run_keys(input int words);
        logic [NUM_KEYS-1:0] edges;
        logic [NUM_KEYS-1:0] levels;
        int k;
        repeat (words) begin
            if ($urandom_range(9) == 0) begin
                edges  = NUM_KEYS'($urandom);
                levels = NUM_KEYS'($urandom);
            end else begin
                edges = '0;
                for (k = 0; k < NUM_KEYS; k++) begin
                    levels[k] = raw_level[k];
                    if (bounce_left[k] > 0) begin
                        bounce_left[k]--;
                        levels[k] = (bounce_left[k] == 0) ? settle_level[k]
                                                          : 1'($urandom_range(1));
                    end else if ($urandom_range(99) < 5) begin
                        settle_level[k] = ~raw_level[k];
                        bounce_left[k]  = int'($urandom_range(4));
                        levels[k] = (bounce_left[k] == 0) ? settle_level[k]
                                                          : 1'($urandom_range(1));
                    end
                    edges[k] = (levels[k] != raw_level[k]) || ($urandom_range(99) < 3);
                end
            end
            raw_level = levels;
            send_tick(edges, levels, 1'b0, '0);
        end
    endtask

    initial begin
        logic [NUM_KEYS-1:0] opposite;
        int k;
        int n;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.edge_mask  = '0;
        tick_ch.key_levels = '0;
        tick_pinned        = 1'b0;
        tick_pinned_rpt    = '0;
        window_len         = WINDOW_RST;
        accept_thr         = THRESH_RST;
        debounced          = '0;
        raw_level          = '0;
        settle_level       = '0;
        for (k = 0; k < NUM_KEYS; k++) begin
            key_timer[k]   = '0;
            miss_count[k]  = '0;
            bounce_left[k] = 0;
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        stall_cycles   = 0;
        fails          = 0;
        ticks_taken    = 0;
        words_checked  = 0;
        toggles_seen   = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == ROW_CFG) begin
                set_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
            end else begin
                send_tick(SCRIPT[i].edges, SCRIPT[i].levels, SCRIPT[i].pinned, SCRIPT[i].want);
            end
        end

        set_reg(REG_WINDOW_TICKS, 8'd8);
        set_reg(REG_ACCEPT_THRESHOLD, 8'd3);
        run_keys(380);

        set_reg(REG_WINDOW_TICKS, 8'd5);
        set_reg(REG_ACCEPT_THRESHOLD, 8'd0);
        send_idle_pct = 80;
        run_keys(300);

        // The result side holds off while ticks keep coming, so the block
        // fills up and has to refuse further words.
        set_reg(REG_WINDOW_TICKS, 8'd12);
        set_reg(REG_ACCEPT_THRESHOLD, 8'd6);
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        hold_left      = 300;
        run_keys(300);

        set_reg(REG_WINDOW_TICKS, 8'd1);
        set_reg(REG_ACCEPT_THRESHOLD, 8'd0);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_keys(200);

        // Every key disagrees for the full longest window, restarted part
        // way through, so the counters must saturate rather than wrap for
        // the keys to toggle at the end.
        set_reg(REG_WINDOW_TICKS, 8'd255);
        set_reg(REG_ACCEPT_THRESHOLD, 8'd254);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        opposite = ~debounced;
        for (n = 0; n < 360; n++) begin
            send_tick((n == 0 || n == 100) ? {NUM_KEYS{1'b1}} : '0, opposite, 1'b0, '0);
        end
        raw_level = opposite;

        set_reg(REG_WINDOW_TICKS, 8'd0);
        set_reg(REG_ACCEPT_THRESHOLD, 8'd255);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_keys(100);

        set_reg(REG_WINDOW_TICKS, 8'd6);
        set_reg(REG_ACCEPT_THRESHOLD, 8'd2);
        run_keys(150);
        drain();
        run_keys(150);

        drain();
        repeat (20) @(posedge i_clk);
        if (reports_due.size() != 0) begin
            $error("%0d result words never arrived", reports_due.size());
            fails++;
        end

        $display("Ran %0d tick words and checked %0d result words with %0d key toggles,",
                 ticks_taken, words_checked, toggles_seen);
        $display("over windows of 0 to 255 ticks, thresholds of 0 to 255 and mixed stalls.");
        if (fails == 0) begin
            $display("multi_key_window_debouncer regression: pass");
        end else begin
            $display("multi_key_window_debouncer regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/mkwd_pkg.sv
sv/mkwd_in_if.sv
sv/mkwd_out_if.sv
sv/mkwd_key.sv
sv/multi_key_window_debouncer.sv
sv/mkwd_checker.sv
dv/multi_key_window_debouncer_test.sv
